// File: hw/rtl/ssct_pkg.sv
// Package for the sorted sparse coordinate table.
// Holds the word types, operation codes, default sizes and tree depth helper.
// No dependencies.
`default_nettype none

package ssct_pkg;

  localparam int unsigned CapacityDef   = 256;
  localparam int unsigned IndexBitsDef  = 16;
  localparam int unsigned TreeFanIn     = 16;
  localparam int unsigned TreeFanBits   = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] row_index;
    logic [15:0] col_index;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        in_range;
    logic        full_res;
    logic [31:0] value_out;
  } res_t;

  // per-cell update strobes, one cycle at commit
  typedef struct packed {
    logic ins_en;
    logic upd_en;
  } cell_ctl_t;

  // registered 16-way OR tree levels needed to cover n leaves
  function automatic int unsigned tree_levels(input int unsigned n);
    int unsigned lvl;
    int unsigned span;
    lvl  = 1;
    span = TreeFanIn;
    while (span < n) begin
      span = span * TreeFanIn;
      lvl  = lvl + 1;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sorted_sparse_coordinate_table_unit.sv
// Sorted sparse coordinate table: ordered chain of entry cells, hit reduction tree, control.
// Depends on ssct_pkg, ssct_cell and ssct_or_tree.
//
// A word is taken when start is high and busy is low. Every word yields one result
// word on res_o, marked by res_valid_o for a single cycle, which the receiver cannot
// stall. A new word is not taken until the last one has committed: the registered
// 16-way OR tree of LEVELS = ceil(log16(CAPACITY)) levels, which gathers the hit flag
// and value word from all cells, sets the time a word takes, and the whole chain of
// cells then compares, shifts or rewrites together.
// No clearing pass is needed after reset.
`default_nettype none

module sorted_sparse_coordinate_table_unit #(
  parameter int unsigned CAPACITY   = ssct_pkg::CapacityDef,
  parameter int unsigned INDEX_BITS = ssct_pkg::IndexBitsDef
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  wire  ssct_pkg::req_t req_i,
  output logic           res_valid_o,
  output ssct_pkg::res_t res_o
);
  import ssct_pkg::*;

  localparam int unsigned KW     = INDEX_BITS;
  localparam int unsigned CW     = 2 * KW;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = tree_levels(CAPACITY);
  localparam int unsigned SW     = $clog2(LEVELS + 1);

  logic             busy_q, busy_d;
  logic [SW-1:0]    stage_q, stage_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KW-1:0]    dim_q, dim_d;
  logic             op_q;
  logic [KW-1:0]    row_q, col_q;
  logic [31:0]      value_q;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  logic [KW-1:0]    row_m, col_m;
  logic             accept;
  logic             commit;
  logic             full;
  logic             in_range;
  logic [32:0]      root;
  logic             hit;
  cell_ctl_t        ctl;

  logic [CW-1:0]    cell_key   [CAPACITY];
  logic [31:0]      cell_value [CAPACITY];
  logic             cell_less  [CAPACITY];
  logic [32:0]      hit_word   [CAPACITY];

  if (KW <= 16) begin : g_idx_narrow
    assign row_m = req_i.row_index[KW-1:0];
    assign col_m = req_i.col_index[KW-1:0];
  end else begin : g_idx_wide
    assign row_m = {{(KW-16){1'b0}}, req_i.row_index};
    assign col_m = {{(KW-16){1'b0}}, req_i.col_index};
  end

  assign accept   = start && !busy_q;
  assign commit   = busy_q && (stage_q == SW'(LEVELS));
  assign full     = count_q == CNT_W'(CAPACITY);
  assign hit      = root[32];
  assign in_range = (row_q <= dim_q) && (col_q <= dim_q);

  always_comb begin
    ctl.ins_en = commit && (op_q == OP_WRITE) && !hit && !full;
    ctl.upd_en = commit && (op_q == OP_WRITE) && hit;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CW-1:0] lkey;
    logic [31:0]   lval;
    logic          lless;
    if (i == 0) begin : g_head
      assign lkey  = '0;
      assign lval  = '0;
      assign lless = 1'b1;
    end else begin : g_body
      assign lkey  = cell_key[i-1];
      assign lval  = cell_value[i-1];
      assign lless = cell_less[i-1];
    end
    ssct_cell #(
      .IDX  (i),
      .KW   (CW),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .key_i       ({row_q, col_q}),
      .value_i     (value_q),
      .left_key_i  (lkey),
      .left_value_i(lval),
      .left_less_i (lless),
      .key_o       (cell_key[i]),
      .value_o     (cell_value[i]),
      .less_o      (cell_less[i]),
      .hit_word_o  (hit_word[i])
    );
  end

  ssct_or_tree #(
    .N     (CAPACITY),
    .W     (33),
    .LEVELS(LEVELS)
  ) u_tree (
    .clk_i (clk_i),
    .leaf_i(hit_word),
    .root_o(root)
  );

  always_comb begin
    busy_d      = busy_q;
    stage_d     = stage_q;
    count_d     = count_q;
    dim_d       = dim_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (accept) begin
      busy_d  = 1'b1;
      stage_d = '0;
    end else if (commit) begin
      busy_d      = 1'b0;
      res_valid_d = 1'b1;
      res_d       = '0;
      if (op_q == OP_WRITE) begin
        res_d.in_range = 1'b1;
        res_d.found    = hit;
        res_d.full_res = !hit && full;
        if (ctl.ins_en) begin
          count_d = count_q + CNT_W'(1);
        end
        if (row_q > dim_d) begin
          dim_d = row_q;
        end
        if (col_q > dim_d) begin
          dim_d = col_q;
        end
      end else begin
        res_d.in_range = in_range;
        if (in_range) begin
          res_d.found     = hit;
          res_d.value_out = root[31:0];
        end
      end
    end else if (busy_q) begin
      stage_d = stage_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      stage_q     <= '0;
      count_q     <= '0;
      dim_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      stage_q     <= stage_d;
      count_q     <= count_d;
      dim_q       <= dim_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      op_q    <= req_i.op;
      row_q   <= row_m;
      col_q   <= col_m;
      value_q <= req_i.value_in;
    end
  end

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_accept_to_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("word accepted but unit not busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(busy) && !busy))
    else $error("result strobe without a word in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.full_res) |-> (!res_o.found && (res_o.value_out == 32'd0)))
    else $error("dropped write reported as hit");

  a_range_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.in_range) |-> (!res_o.found && (res_o.value_out == 32'd0)))
    else $error("out-of-range read returned data");

endmodule

`default_nettype wire

// File: hw/rtl/ssct_cell.sv
// One entry of the ordered coordinate chain: key, value word and local compare.
// Takes the new word or its left neighbour's on insert, rewrites its value on a hit.
// Depends on ssct_pkg.
`default_nettype none

module ssct_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned KW    = 32,
  parameter int unsigned CNT_W = 9
) (
  input  wire                       clk_i,
  input  wire ssct_pkg::cell_ctl_t  ctl_i,
  input  wire  [CNT_W-1:0]          count_i,
  input  wire  [KW-1:0]             key_i,
  input  wire  [31:0]               value_i,
  input  wire  [KW-1:0]             left_key_i,
  input  wire  [31:0]               left_value_i,
  input  wire                       left_less_i,
  output logic [KW-1:0]             key_o,
  output logic [31:0]               value_o,
  output logic                      less_o,
  output logic [32:0]               hit_word_o
);
  import ssct_pkg::*;

  logic [KW-1:0] key_q, key_d;
  logic [31:0]   value_q, value_d;
  logic          valid;
  logic          eq;

  assign valid  = count_i > CNT_W'(IDX);
  assign less_o = valid && (key_q < key_i);
  assign eq     = valid && (key_q == key_i);

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctl_i.ins_en && !less_o) begin
      if (left_less_i) begin
        key_d   = key_i;
        value_d = value_i;
      end else begin
        key_d   = left_key_i;
        value_d = left_value_i;
      end
    end else if (ctl_i.upd_en && eq) begin
      value_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o      = key_q;
  assign value_o    = value_q;
  assign hit_word_o = eq ? {1'b1, value_q} : 33'd0;

endmodule

`default_nettype wire

// File: hw/rtl/ssct_or_tree.sv
// Registered 16-way OR reduction over the cell hit words.
// One register level per 16-way stage; the root is the output of the last level.
// Depends on ssct_pkg.
`default_nettype none

module ssct_or_tree #(
  parameter int unsigned N      = 256,
  parameter int unsigned W      = 33,
  parameter int unsigned LEVELS = 2
) (
  input  wire          clk_i,
  input  wire  [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);
  import ssct_pkg::*;

  localparam int unsigned NPAD = TreeFanIn ** LEVELS;

  logic [W-1:0] node_q [LEVELS][NPAD];
  logic [W-1:0] node_d [LEVELS][NPAD];

  always_comb begin
    for (int unsigned n = 0; n < NPAD; n++) begin
      node_d[0][n] = '0;
      if (n < (NPAD >> TreeFanBits)) begin
        for (int unsigned c = 0; c < TreeFanIn; c++) begin
          if ((n * TreeFanIn + c) < N) begin
            node_d[0][n] = node_d[0][n] | leaf_i[n * TreeFanIn + c];
          end
        end
      end
    end
    for (int unsigned l = 1; l < LEVELS; l++) begin
      for (int unsigned n = 0; n < NPAD; n++) begin
        node_d[l][n] = '0;
        if (n < (NPAD >> (TreeFanBits * (l + 1)))) begin
          for (int unsigned c = 0; c < TreeFanIn; c++) begin
            node_d[l][n] = node_d[l][n] | node_q[l-1][n * TreeFanIn + c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
  end

  assign root_o = node_q[LEVELS-1][0];

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for sorted_sparse_coordinate_table_unit.
// A directed table, then random writes and reads checked against a coordinate-keyed predictor.
// Depends on ssct_pkg and the RTL of the block.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssct_pkg::*;

  localparam int unsigned TableDepth = CapacityDef;
  localparam int RandWords    = 1630;
  localparam int PhaseAWords  = 650;
  localparam int PoolNear     = 256;
  localparam int PoolSize     = 384;
  localparam int IdleLimit    = 2000;
  localparam int TailCycles   = 20;

  typedef struct packed {
    logic typed;
    req_t word;
    res_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  logic [31:0] cell_value [logic [31:0]];
  logic [15:0] dim_q = '0;
  res_t        pending_res [$];
  dir_row_t    dir_tab [$];
  logic [31:0] coord_pool [PoolSize];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          steady_run = 1'b0;

  sorted_sparse_coordinate_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // predicted table behaviour; order of entries does not affect results
  function automatic res_t coord_access(input req_t w);
    res_t        r;
    logic [31:0] key;
    r          = '0;
    r.in_range = 1'b1;
    key        = {w.row_index, w.col_index};
    if (w.op == OP_WRITE) begin
      if (w.row_index > dim_q) dim_q = w.row_index;
      if (w.col_index > dim_q) dim_q = w.col_index;
      if (cell_value.exists(key)) begin
        cell_value[key] = w.value_in;
        r.found         = 1'b1;
      end else if (cell_value.num() >= TableDepth) begin
        r.full_res = 1'b1;
      end else begin
        cell_value[key] = w.value_in;
      end
    end else if (w.row_index > dim_q || w.col_index > dim_q) begin
      r.in_range = 1'b0;
    end else if (cell_value.exists(key)) begin
      r.found     = 1'b1;
      r.value_out = cell_value[key];
    end
    return r;
  endfunction

  function automatic dir_row_t tab_row(input logic typed, input logic op,
                                       input logic [15:0] row, input logic [15:0] col,
                                       input logic [31:0] val, input logic f,
                                       input logic ir, input logic fu,
                                       input logic [31:0] vo);
    dir_row_t d;
    d.typed = typed;
    d.word  = '{op: op, row_index: row, col_index: col, value_in: val};
    d.res   = '{found: f, in_range: ir, full_res: fu, value_out: vo};
    return d;
  endfunction

  task automatic add_row(input logic typed, input logic op,
                         input logic [15:0] row, input logic [15:0] col,
                         input logic [31:0] val, input logic f,
                         input logic ir, input logic fu,
                         input logic [31:0] vo);
    dir_tab.insert(dir_tab.size(), tab_row(typed, op, row, col, val, f, ir, fu, vo));
  endtask

  task automatic send_word(input req_t w, input logic typed, input res_t typed_res);
    int   gap;
    res_t pred;
    gap = steady_run ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    pred = coord_access(w);
    pending_res.insert(pending_res.size(), typed ? typed_res : pred);
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected word", res_o.value_out, '0);
      end else begin
        want = pending_res.pop_front();
        if (res_o.found !== want.found)
          report_mismatch("found", 32'(res_o.found), 32'(want.found));
        if (res_o.in_range !== want.in_range)
          report_mismatch("in_range", 32'(res_o.in_range), 32'(want.in_range));
        if (res_o.full_res !== want.full_res)
          report_mismatch("full_res", 32'(res_o.full_res), 32'(want.full_res));
        if (res_o.value_out !== want.value_out)
          report_mismatch("value_out", res_o.value_out, want.value_out);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    req_t        w;
    logic [31:0] key;
    int          sel;
    logic [15:0] near_max;

    add_row(1, OP_READ,  16'h0000, 16'h0000, 32'hDEAD_BEEF, 0, 1, 0, 0);
    add_row(1, OP_READ,  16'h0001, 16'h0000, 32'h0, 0, 0, 0, 0);
    add_row(1, OP_READ,  16'h0000, 16'h0001, 32'h0, 0, 0, 0, 0);
    add_row(1, OP_WRITE, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 0, 1, 0, 0);
    add_row(1, OP_READ,  16'h0000, 16'h0000, 32'h0, 1, 1, 0, 32'hFFFF_FFFF);
    add_row(1, OP_WRITE, 16'h0000, 16'h0000, 32'h0, 1, 1, 0, 0);
    add_row(1, OP_READ,  16'h0000, 16'h0000, 32'h0, 1, 1, 0, 0);
    add_row(1, OP_READ,  16'hFFFF, 16'hFFFF, 32'h0, 0, 0, 0, 0);
    add_row(1, OP_WRITE, 16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5, 0, 1, 0, 0);
    add_row(1, OP_READ,  16'hFFFF, 16'hFFFF, 32'h0, 1, 1, 0, 32'hA5A5_A5A5);
    add_row(1, OP_READ,  16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 0, 1, 0, 0);
    add_row(1, OP_WRITE, 16'h0000, 16'hFFFF, 32'h0000_0001, 0, 1, 0, 0);
    add_row(1, OP_WRITE, 16'hFFFF, 16'h0000, 32'h0000_0002, 0, 1, 0, 0);
    add_row(0, OP_WRITE, 16'h0005, 16'h0003, 32'h1234_5678, 0, 0, 0, 0);
    add_row(0, OP_WRITE, 16'h0005, 16'h0002, 32'h5A5A_0F0F, 0, 0, 0, 0);
    add_row(0, OP_WRITE, 16'h0003, 16'h0009, 32'h8000_0000, 0, 0, 0, 0);
    add_row(0, OP_READ,  16'h0005, 16'h0003, 32'h0, 0, 0, 0, 0);
    add_row(0, OP_READ,  16'h0005, 16'h0002, 32'h0, 0, 0, 0, 0);
    add_row(0, OP_READ,  16'h0003, 16'h0009, 32'h0, 0, 0, 0, 0);
    add_row(0, OP_READ,  16'h0004, 16'h0004, 32'h0, 0, 0, 0, 0);
    add_row(0, OP_WRITE, 16'h0005, 16'h0003, 32'h0000_7FFF, 0, 0, 0, 0);
    add_row(0, OP_READ,  16'h0005, 16'h0003, 32'h0, 0, 0, 0, 0);
    add_row(0, OP_READ,  16'h0000, 16'hFFFF, 32'h0, 0, 0, 0, 0);
    add_row(0, OP_READ,  16'hFFFF, 16'h0000, 32'h0, 0, 0, 0, 0);

    // near coordinates have row and column below 64; phase A writes only these
    for (int i = 0; i < PoolSize; i++) begin
      if (i < PoolNear) coord_pool[i] = {16'($urandom_range(0, 63)), 16'($urandom_range(0, 63))};
      else coord_pool[i] = $urandom;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows run from reset state, dimension zero
    foreach (dir_tab[i]) begin
      if (i % 8 == 0) steady_run = ($urandom_range(0, 3) == 0);
      send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);
    end

    // a second dimension reset is not done, and the directed rows leave the dimension at FFFF:
    // phase A writes only near coordinates, phase B opens the full range and fills the table
    for (int n = 0; n < RandWords; n++) begin
      if (n % 40 == 0) steady_run = ($urandom_range(0, 3) == 0);
      w.value_in = $urandom;
      w.op       = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
      sel        = $urandom_range(0, 99);
      near_max   = 16'($urandom_range(0, 127));
      if (w.op == OP_WRITE) begin
        if (n < PhaseAWords) key = coord_pool[$urandom_range(0, PoolNear - 1)];
        else if (sel < 70) key = coord_pool[$urandom_range(0, PoolSize - 1)];
        else key = $urandom;
      end else begin
        if (sel < 65) key = coord_pool[$urandom_range(0, PoolSize - 1)];
        else if (sel < 85) key = {near_max, 16'($urandom_range(0, 127))};
        else key = $urandom;
      end
      w.row_index = key[31:16];
      w.col_index = key[15:0];
      send_word(w, 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
